FILE: sv/grps_pkg.sv
// types and constants for the greedy radius point subsampler
// no dependencies
package grps_pkg;

   localparam int ID_BITS     = 20;
   localparam int RADIUS_BITS = 50;
   localparam int CFG_IDX_BITS = 2;
   localparam int CFG_DATA_BITS = 64;
   localparam int CORD_W      = 24;

   localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_COUNT   = 2'd0;
   localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_COUNT   = 2'd1;
   localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_SQUARED = 2'd2;

   typedef struct packed {
      logic                      first_point;
      logic [ID_BITS-1:0]        vertex_id;
      logic signed [CORD_W-1:0]  x_coord;
      logic signed [CORD_W-1:0]  y_coord;
      logic signed [CORD_W-1:0]  z_coord;
   } req_type;

   typedef struct packed {
      logic               kept;
      logic [ID_BITS-1:0] node_id;
      logic               overflow;
   } rsp_type;

endpackage

FILE: sv/grps_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module grps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: sv/grps_front.sv
// front part: takes a command beat, decides bypass, and queues it for the scan
// depends on grps_pkg
module grps_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  grps_pkg::req_type  req_data,
   input  logic [19:0]        vertex_count,
   input  logic [19:0]        target_count,
   output logic               q_valid,
   output grps_pkg::req_type  q_data,
   output logic               q_bypass,
   input  logic               q_pop
);
   import grps_pkg::*;

   // two-entry queue
   req_type q_data_ff [2];
   logic    q_byp_ff  [2];
   logic    wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic    push;

   assign busy     = (cnt_ff == 2'd2);
   assign push     = start && !busy;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_data   = q_data_ff[rp_ff];
   assign q_bypass = q_byp_ff[rp_ff];

   always_comb begin
      wp_in  = push  ? ~wp_ff : wp_ff;
      rp_in  = q_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_data_ff[wp_ff] <= req_data;
         q_byp_ff[wp_ff]  <= (vertex_count <= target_count);
      end
   end
endmodule

FILE: sv/grps_back.sv
// back part: scans the kept table one entry a cycle and emits one result
// depends on grps_pkg, grps_ram
module grps_back #(
   parameter int MAX_NODES  = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  grps_pkg::req_type  q_data,
   input  logic               q_bypass,
   output logic               q_pop,
   input  logic [49:0]        radius_squared,
   output logic               rsp_valid,
   output grps_pkg::rsp_type  rsp_data
);
   import grps_pkg::*;

   localparam int AW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int DW = CORD_W;            // offset diff magnitude bits
   localparam int SW = 2 * DW + 2;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_CMP  = 4'b0100,
      S_SUM  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] idx_ff, idx_in;       // entry address being issued
   logic [DW-1:0] vx_ff, vy_ff, vz_ff;  // offset-binary coords of current vertex
   logic          hit_ff, hit_in;
   logic          rv_ff, rv_in;         // read data valid next cycle
   logic          sv_ff, sv_in;         // squares valid
   logic [2*DW-1:0] sqx_ff, sqy_ff, sqz_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic [DW-1:0] rdx, rdy, rdz, dx, dy, dz;
   logic [SW-1:0] sq_sum;
   logic          wr_en;
   logic [AW-1:0] rd_addr;

   function automatic logic [DW-1:0] absdiff(input logic [DW-1:0] a, input logic [DW-1:0] b);
      absdiff = (a > b) ? (a - b) : (b - a);
   endfunction

   assign rd_addr = idx_ff[AW-1:0];
   assign dx = absdiff(vx_ff, rdx);
   assign dy = absdiff(vy_ff, rdy);
   assign dz = absdiff(vz_ff, rdz);
   assign sq_sum = SW'(sqx_ff) + SW'(sqy_ff) + SW'(sqz_ff);
   assign q_pop = (state_ff == S_IDLE) && q_valid;

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      rv_in        = 1'b0;
      sv_in        = rv_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      wr_en        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               if (q_data.first_point) begin
                  total_in = '0;
               end
               if (q_bypass) begin
                  rsp_valid_in   = 1'b1;
                  rsp_in.kept    = 1'b1;
                  rsp_in.node_id = q_data.vertex_id;
               end else begin
                  idx_in   = '0;
                  hit_in   = 1'b0;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            // issue reads while entries remain and no hit seen
            if (idx_ff < total_ff && !hit_ff) begin
               rv_in  = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else if (!rv_ff && !sv_ff) begin
               state_in = S_SUM;
            end
            if (sv_ff && (sq_sum < SW'(radius_squared))) begin
               hit_in = 1'b1;
            end
         end
         S_SUM: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (hit_ff) begin
               rsp_in = '0;
            end else if (total_ff >= CW'(MAX_NODES)) begin
               rsp_in.overflow = 1'b1;
            end else begin
               wr_en          = 1'b1;
               rsp_in.kept    = 1'b1;
               rsp_in.node_id = ID_BITS'(total_ff);
               total_in       = total_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         idx_ff       <= '0;
         hit_ff       <= 1'b0;
         rv_ff        <= 1'b0;
         sv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         idx_ff       <= idx_in;
         hit_ff       <= hit_in;
         rv_ff        <= rv_in;
         sv_ff        <= sv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      sqx_ff <= dx * dx;
      sqy_ff <= dy * dy;
      sqz_ff <= dz * dz;
      if (q_pop) begin
         vx_ff  <= {~q_data.x_coord[DW-1], q_data.x_coord[DW-2:0]};
         vy_ff  <= {~q_data.y_coord[DW-1], q_data.y_coord[DW-2:0]};
         vz_ff  <= {~q_data.z_coord[DW-1], q_data.z_coord[DW-2:0]};
      end
   end

   grps_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_ram_x (
      .clock(clock), .wr_en(wr_en), .wr_addr(total_ff[AW-1:0]), .wr_data(vx_ff),
      .rd_addr(rd_addr), .rd_data(rdx));
   grps_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_ram_y (
      .clock(clock), .wr_en(wr_en), .wr_addr(total_ff[AW-1:0]), .wr_data(vy_ff),
      .rd_addr(rd_addr), .rd_data(rdy));
   grps_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_ram_z (
      .clock(clock), .wr_en(wr_en), .wr_addr(total_ff[AW-1:0]), .wr_data(vz_ff),
      .rd_addr(rd_addr), .rd_data(rdz));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

FILE: sv/greedy_radius_point_subsample.sv
// greedy radius point subsampler top level
// a bypassed vertex skips the scan; otherwise the time per vertex grows with kept_total
// (less with an empty table, or when a close point ends the scan early), set by the scan of the
// kept table, one entry a cycle through the coordinate rams
// a two-beat command queue lets start be taken while the scan runs
// synchronous active-high reset clears config to defaults and empties the table
// results go out on rsp_valid for one cycle; the receiver cannot stall
module greedy_radius_point_subsample #(
   parameter int MAX_NODES  = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  grps_pkg::req_type    req_data,
   output logic                 rsp_valid,
   output grps_pkg::rsp_type    rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [63:0]          csr_wdata
);
   import grps_pkg::*;

   logic [19:0] vcount_ff, tcount_ff;
   logic [49:0] radius_ff;
   logic        q_valid, q_bypass, q_pop;
   req_type     q_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
         tcount_ff <= 20'd1;
         radius_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_VERTEX_COUNT:   vcount_ff <= csr_wdata[19:0];
            REG_TARGET_COUNT:   tcount_ff <= csr_wdata[19:0];
            REG_RADIUS_SQUARED: radius_ff <= csr_wdata[49:0];
            default: ;
         endcase
      end
   end

   grps_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .vertex_count(vcount_ff), .target_count(tcount_ff),
      .q_valid(q_valid), .q_data(q_data), .q_bypass(q_bypass), .q_pop(q_pop));

   grps_back #(.MAX_NODES(MAX_NODES)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_data(q_data),
      .q_bypass(q_bypass), .q_pop(q_pop), .radius_squared(radius_ff),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data));

   // a result never claims both kept and overflow
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.kept && rsp_data.overflow)) else $error("kept and overflow");
   // a pop always comes from a filled queue
   a_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop of empty queue");
   // no pop is made while the queue stays empty
   a_idle: assert property (@(posedge clock) disable iff (reset)
      !$past(q_valid) && !q_valid && $past(!q_valid, 2) |-> !$past(q_pop))
      else $error("pop without data");
endmodule
